// File: design/clt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and codes for the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int KIND_W = 2;
    localparam int POS_W  = 16;
    localparam int CNT_W  = 7;
    localparam int LINE_W = 16;

    localparam logic [KIND_W-1:0] KIND_ARG       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUOTE_ERR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_MANY_ERR  = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [CNT_W-1:0] MAX_ARGS_RESET = 7'd64;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  length;
        logic [CNT_W-1:0]  arg_number;
        logic [LINE_W-1:0] line_number;
        logic              last_result;
    } t_result;

endpackage

// File: design/command_line_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer_top
// Splits a script buffer into arguments and lines, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : i_in_valid / o_in_stall with i_byte_in and i_last_byte
//   output channel : o_out_valid / i_out_stall with kind, position, length,
//                    arg_number, line_number and last_result
//   config port    : APB-style, max_args at byte address 0, pready always high
// Each accepted byte is decoded in the cycle it is taken and gives zero, one
// or two results, which enter a four-entry result queue at the next edge, so
// the first result is visible in the cycle after the byte transfer. One byte
// is taken every cycle unless stalled; the output side moves one result per
// cycle unless the receiver stalls, so a run of bytes that each give two
// results is paced by the queue drain. The input is stalled whenever fewer
// than two queue slots are free. A stalled receiver holds the head result;
// the queue fills and then holds off the input. Reset empties the queue,
// returns the scan state to the start of a buffer (line 1, offset 0) and sets
// max_args to 64. The last byte of a buffer does the same to the scan state.
// ----------------------------------------------------------------------------
module command_line_tokenizer_top #(
    parameter int OFFSET_BITS = 16,
    parameter int ARG_LIMIT   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_last_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_position,
    output logic [15:0] o_length,
    output logic [6:0]  o_arg_number,
    output logic [15:0] o_line_number,
    output logic        o_last_result,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import clt_pkg::*;

    localparam logic [1:0] MODE_BETWEEN  = 2'd0;
    localparam logic [1:0] MODE_UNQUOTED = 2'd1;
    localparam logic [1:0] MODE_QUOTED   = 2'd2;
    localparam logic [1:0] MODE_DROP     = 2'd3;

    localparam logic ADDR_MAX_ARGS = 1'b0;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [LINE_W-1:0]      LINE_MAX = {LINE_W{1'b1}};
    localparam logic [LINE_W-1:0]      LINE_ONE = LINE_W'(1);

    // scan state
    logic [1:0]             r_mode;
    logic [OFFSET_BITS-1:0] r_start;
    logic [OFFSET_BITS-1:0] r_off;
    logic [CNT_W-1:0]       r_cnt;
    logic [LINE_W-1:0]      r_line;
    logic [CNT_W-1:0]       r_max_args;

    logic [1:0]             n_mode;
    logic [OFFSET_BITS-1:0] n_start;
    logic [OFFSET_BITS-1:0] n_off;
    logic [CNT_W-1:0]       n_cnt;
    logic [LINE_W-1:0]      n_line;

    // result queue
    t_result                r_q [QDEPTH];
    logic [QPTR_W-1:0]      r_wr;
    logic [QPTR_W-1:0]      r_rd;
    logic [QCNT_W-1:0]      r_qcnt;

    t_result                w_res [2];
    logic [1:0]             w_nres;
    logic [8:0]             w_lim;
    logic                   w_in_acc;
    logic                   w_out_acc;
    logic                   w_cfg_wr;
    t_result                w_head;

    function automatic t_result mk_res(
        input logic [KIND_W-1:0]      kind,
        input logic [OFFSET_BITS-1:0] pos,
        input logic [OFFSET_BITS-1:0] len,
        input logic [CNT_W-1:0]       num,
        input logic [LINE_W-1:0]      line
    );
        t_result r;
        r.kind        = kind;
        r.position    = POS_W'(pos);
        r.length      = POS_W'(len);
        r.arg_number  = num;
        r.line_number = line;
        r.last_result = 1'b0;
        return r;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] arg_len(
        input logic [OFFSET_BITS-1:0] start,
        input logic [OFFSET_BITS-1:0] stop
    );
        return (stop >= start) ? (stop - start) : '0;
    endfunction

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    // limit in force is the smaller of max_args and the build limit
    assign w_lim = ({2'b00, r_max_args} < 9'(ARG_LIMIT)) ? {2'b00, r_max_args}
                                                          : 9'(ARG_LIMIT);

    always_comb begin
        logic [1:0]             m;
        logic [OFFSET_BITS-1:0] st;
        logic [CNT_W-1:0]       cnt;
        logic [LINE_W-1:0]      ln;
        logic [OFFSET_BITS-1:0] off_nx;
        logic                   sep;
        logic                   lf;
        logic                   qt;
        logic                   ended;
        logic                   many;
        t_result                r;

        m      = r_mode;
        st     = r_start;
        cnt    = r_cnt;
        ln     = r_line;
        ended  = 1'b0;
        r      = '0;
        w_res[0] = '0;
        w_res[1] = '0;
        w_nres = 2'd0;
        off_nx = (r_off == OFF_MAX) ? r_off : r_off + 1'b1;
        sep    = (i_byte_in == CH_SPACE) || (i_byte_in == CH_TAB) || (i_byte_in == CH_CR);
        lf     = (i_byte_in == CH_LF);
        qt     = (i_byte_in == CH_QUOTE);
        // at most one argument is closed per byte, so the check uses the stored count
        many   = ({2'b00, r_cnt} >= w_lim);

        unique case (r_mode)
            MODE_BETWEEN: begin
                if (lf) begin
                    w_res[0] = mk_res(KIND_LINE, '0, '0, cnt, ln);
                    w_nres   = 2'd1;
                    cnt      = '0;
                    ln       = (ln == LINE_MAX) ? ln : ln + 1'b1;
                    ended    = 1'b1;
                end else if (qt) begin
                    m  = MODE_QUOTED;
                    st = off_nx;
                end else if (!sep) begin
                    m  = MODE_UNQUOTED;
                    st = r_off;
                end
            end
            MODE_UNQUOTED: begin
                if (lf || sep || qt) begin
                    if (many) begin
                        w_res[0] = mk_res(KIND_MANY_ERR, st, '0, cnt, ln);
                        w_nres   = 2'd1;
                        m        = MODE_DROP;
                    end else begin
                        w_res[0] = mk_res(KIND_ARG, st, arg_len(st, r_off), cnt, ln);
                        w_nres   = 2'd1;
                        cnt      = cnt + 1'b1;
                        if (lf) begin
                            m        = MODE_BETWEEN;
                            w_res[1] = mk_res(KIND_LINE, '0, '0, cnt, ln);
                            w_nres   = 2'd2;
                            cnt      = '0;
                            ln       = (ln == LINE_MAX) ? ln : ln + 1'b1;
                        end else if (sep) begin
                            m = MODE_BETWEEN;
                        end else begin
                            m  = MODE_QUOTED;
                            st = off_nx;
                        end
                    end
                    ended = lf;
                end
            end
            MODE_QUOTED: begin
                if (qt) begin
                    if (many) begin
                        w_res[0] = mk_res(KIND_MANY_ERR, st, '0, cnt, ln);
                        m        = MODE_DROP;
                    end else begin
                        w_res[0] = mk_res(KIND_ARG, st, arg_len(st, r_off), cnt, ln);
                        cnt      = cnt + 1'b1;
                        m        = MODE_BETWEEN;
                    end
                    w_nres = 2'd1;
                end else if (lf || (i_byte_in == CH_CR)) begin
                    w_res[0] = mk_res(KIND_QUOTE_ERR, st, '0, cnt, ln);
                    w_nres   = 2'd1;
                    m        = MODE_DROP;
                end
            end
            MODE_DROP: begin
                m = MODE_DROP;
            end
            default: begin
                m = MODE_DROP;
            end
        endcase

        // end of buffer flushes whatever is open
        if (i_last_byte) begin
            if (m == MODE_QUOTED) begin
                r = mk_res(KIND_QUOTE_ERR, st, '0, cnt, ln);
            end else if (m == MODE_UNQUOTED) begin
                if (many) begin
                    r = mk_res(KIND_MANY_ERR, st, '0, cnt, ln);
                end else begin
                    r = mk_res(KIND_ARG, st, arg_len(st, off_nx), cnt, ln);
                end
            end else if (m == MODE_BETWEEN && !ended) begin
                r = mk_res(KIND_LINE, '0, '0, cnt, ln);
            end
            if (m == MODE_QUOTED || m == MODE_UNQUOTED || (m == MODE_BETWEEN && !ended)) begin
                w_res[w_nres[0]] = r;
                w_nres = w_nres + 2'd1;
            end
            if (m == MODE_UNQUOTED && !many) begin
                w_res[w_nres[0]] = mk_res(KIND_LINE, '0, '0, cnt + 1'b1, ln);
                w_nres = w_nres + 2'd1;
            end
            n_mode  = MODE_BETWEEN;
            n_start = '0;
            n_off   = '0;
            n_cnt   = '0;
            n_line  = LINE_ONE;
        end else begin
            n_mode  = m;
            n_start = st;
            n_off   = off_nx;
            n_cnt   = cnt;
            n_line  = ln;
        end

        if (w_nres == 2'd1) begin
            w_res[0].last_result = 1'b1;
        end else if (w_nres == 2'd2) begin
            w_res[1].last_result = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_BETWEEN;
            r_start    <= '0;
            r_off      <= '0;
            r_cnt      <= '0;
            r_line     <= LINE_ONE;
            r_max_args <= MAX_ARGS_RESET;
        end else begin
            if (w_in_acc) begin
                r_mode  <= n_mode;
                r_start <= n_start;
                r_off   <= n_off;
                r_cnt   <= n_cnt;
                r_line  <= n_line;
            end
            if (w_cfg_wr && paddr[2] == ADDR_MAX_ARGS) begin
                r_max_args <= pwdata[CNT_W-1:0];
            end
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_qcnt <= '0;
        end else begin
            if (w_in_acc) begin
                r_wr <= r_wr + QPTR_W'(w_nres);
            end
            if (w_out_acc) begin
                r_rd <= r_rd + 1'b1;
            end
            r_qcnt <= r_qcnt + (w_in_acc ? QCNT_W'(w_nres) : '0)
                             - (w_out_acc ? QCNT_W'(1) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_nres != 2'd0) begin
            r_q[r_wr] <= w_res[0];
        end
        if (w_in_acc && w_nres == 2'd2) begin
            r_q[r_wr + 1'b1] <= w_res[1];
        end
    end

    // two free slots are needed for a byte that closes an argument and a line
    assign o_in_stall  = (r_qcnt > QCNT_W'(QDEPTH - 2));
    assign o_out_valid = (r_qcnt != '0);

    assign w_head        = r_q[r_rd];
    assign o_kind        = w_head.kind;
    assign o_position    = w_head.position;
    assign o_length      = w_head.length;
    assign o_arg_number  = w_head.arg_number;
    assign o_line_number = w_head.line_number;
    assign o_last_result = w_head.last_result;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_MAX_ARGS) ? {{(32 - CNT_W){1'b0}}, r_max_args} : '0;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= QCNT_W'(QDEPTH))
        else $error("result queue count beyond depth");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_last_byte |=>
            r_mode == MODE_BETWEEN && r_off == '0 && r_cnt == '0 && r_line == LINE_ONE)
        else $error("scan state not cleared after last byte");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_last_byte && r_mode != MODE_DROP |=> r_qcnt != '0)
        else $error("last byte left no result");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line number reached zero");

endmodule
